@@ design/gmm_pkg.sv @@
package gmm_pkg;

  // Frame and mixture sizes
  localparam int PIXEL_COUNT = 262144;
  localparam int IDX_W       = 18;
  localparam int MAX_COMP    = 3;
  localparam int CNT_W       = 2;
  localparam int SLOT_W      = 2;
  localparam int ENTRY_W     = 64;
  localparam int ROW_W       = MAX_COMP * ENTRY_W;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SIGMA      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VARIANCE = 3'd4;

  localparam logic [15:0] RST_LEARN_RATE       = 16'd6554;
  localparam logic [11:0] RST_MATCH_SIGMA      = 12'd640;
  localparam logic [7:0]  RST_MASK_THRESHOLD   = 8'd20;
  localparam logic [15:0] RST_INITIAL_WEIGHT   = 16'd66;
  localparam logic [23:0] RST_INITIAL_VARIANCE = 24'd230400;

  localparam logic [7:0] MASK_BG = 8'd0;
  localparam logic [7:0] MASK_FG = 8'd255;

  typedef struct packed {
    logic [7:0]       pixel_value;
    logic [IDX_W-1:0] pixel_index;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]       mask_value;
    logic [IDX_W-1:0] pixel_position;
  } pix_out_t;

  // Request from the sequencer to the pixel store
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] count;
  } st_req_t;

  typedef enum logic [26:0] {
    S_IDLE  = 27'h0000001,
    S_RD    = 27'h0000002,
    S_MD    = 27'h0000004,
    S_MV    = 27'h0000008,
    S_MT    = 27'h0000010,
    S_DW    = 27'h0000020,
    S_DW2   = 27'h0000040,
    S_UM1   = 27'h0000080,
    S_UM2   = 27'h0000100,
    S_UM3   = 27'h0000200,
    S_UV1   = 27'h0000400,
    S_UV2   = 27'h0000800,
    S_UV3   = 27'h0001000,
    S_UV4   = 27'h0002000,
    S_UW1   = 27'h0004000,
    S_UW2   = 27'h0008000,
    S_NEW   = 27'h0010000,
    S_SUM   = 27'h0020000,
    S_DIV   = 27'h0040000,
    S_DIVW  = 27'h0080000,
    S_R1    = 27'h0100000,
    S_R2    = 27'h0200000,
    S_R3    = 27'h0400000,
    S_R4    = 27'h0800000,
    S_R5    = 27'h1000000,
    S_WRITE = 27'h2000000,
    S_DONE  = 27'h4000000
  } state_t;

endpackage

@@ design/gmm_mul.sv @@
module gmm_mul (
  input  logic                          clk,
  input  logic [gmm_pkg::MUL_A_W-1:0]   a,
  input  logic [gmm_pkg::MUL_B_W-1:0]   b,
  output logic [gmm_pkg::MUL_P_W-1:0]   p
);
  import gmm_pkg::*;

  // Register the product every cycle
  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

@@ design/gmm_div.sv @@
module gmm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [17:0] divisor,
  output logic        done,
  output logic [16:0] quot
);
  import gmm_pkg::*;

  logic        run;
  logic [4:0]  cnt;
  logic [18:0] rem;
  logic        ge;
  logic [18:0] rem_sub;

  // One quotient bit per cycle; dividend never exceeds divisor
  assign ge      = rem >= {1'b0, divisor};
  assign rem_sub = ge ? rem - {1'b0, divisor} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'd17;
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {3'b000, dividend};
      quot <= '0;
    end else if (run) begin
      quot <= {quot[15:0], ge};
      rem  <= {rem_sub[17:0], 1'b0};
    end
  end

endmodule

@@ design/gmm_store.sv @@
module gmm_store (
  input  logic                          clk,
  input  logic                          rst,
  input  gmm_pkg::st_req_t              req,
  input  logic [gmm_pkg::ROW_W-1:0]     wr_row,
  output logic [gmm_pkg::CNT_W-1:0]     rd_count,
  output logic [gmm_pkg::ROW_W-1:0]     rd_row,
  output logic                          clearing
);
  import gmm_pkg::*;

  logic [CNT_W-1:0] count_mem [PIXEL_COUNT];
  logic [ROW_W-1:0] row_mem   [PIXEL_COUNT];
  logic [IDX_W-1:0] clr_addr;

  // Sweep the count memory to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(PIXEL_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Count memory: clear sweep or writeback, registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      count_mem[clr_addr] <= '0;
    end else if (req.wr) begin
      count_mem[req.addr] <= req.count;
    end
    if (req.rd) begin
      rd_count <= count_mem[req.addr];
    end
  end

  // Component rows, one per pixel, in rank order
  always_ff @(posedge clk) begin
    if (req.wr) begin
      row_mem[req.addr] <= wr_row;
    end
    if (req.rd) begin
      rd_row <= row_mem[req.addr];
    end
  end

endmodule

@@ design/gmm_background_subtractor.sv @@
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_ready  in_data  (pixel_value, pixel_index)
// out      out  out_valid/out_ready out_data (mask_value, pixel_position)
// cfg      in   cfg_we             cfg_index, cfg_data
//
// Each item is worked through one component at a time on the shared registered
// multiplier: every component is match-tested and then decayed, or updated when it matches;
// up to three rank compares run per sort, and each weight goes through the bit-serial
// normalizing divider, which is skipped when all weights are zero. After reset a
// clearing pass zeroes the per-pixel counts; no item is taken meanwhile. A finished
// result waits in the output register while the next item runs.
module gmm_background_subtractor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  gmm_pkg::pix_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output gmm_pkg::pix_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [gmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gmm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gmm_pkg::*;

  // Configuration registers
  logic [15:0] learn_rate;
  logic [11:0] match_sigma;
  logic [7:0]  mask_threshold;
  logic [15:0] initial_weight;
  logic [23:0] initial_variance;

  state_t state;

  logic [7:0]       x;
  logic [IDX_W-1:0] idx;
  logic             oor;
  logic [23:0]      sig2;
  logic [SLOT_W-1:0] i;
  logic [CNT_W-1:0] n;
  logic             found;
  logic [1:0]       ss;
  logic             pass;
  logic [17:0]      sum;
  logic [MUL_P_W-1:0] tmp;

  logic [15:0] cw [MAX_COMP];
  logic [15:0] cm [MAX_COMP];
  logic [23:0] cv [MAX_COMP];
  logic [7:0]  cl [MAX_COMP];

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic        div_start;
  logic        div_done;
  logic [16:0] quot;

  st_req_t          st_req;
  logic [ROW_W-1:0] wr_row;
  logic [CNT_W-1:0] rd_count;
  logic [ROW_W-1:0] rd_row;
  logic             clearing;

  logic [16:0] keep;
  logic [15:0] xs;
  logic [15:0] ad;
  logic        last_i;
  logic [SLOT_W-1:0] hi;
  logic [SLOT_W-1:0] lo;
  logic [SLOT_W-1:0] new_slot;
  logic        in_acc;
  logic        match;
  logic [33:0] mean_sum;
  logic [49:0] var_sum;
  logic [32:0] dec_sum;
  logic [33:0] wt_sum;
  logic [17:0] sum_all;
  logic [7:0]  mdiff;

  assign in_ready = (state == S_IDLE) && !clearing;
  assign in_acc   = in_valid && in_ready;

  // Shared arithmetic helpers
  assign keep     = 17'h10000 - {1'b0, learn_rate};
  assign xs       = {x, 8'h00};
  assign ad       = (xs >= cm[i]) ? xs - cm[i] : cm[i] - xs;
  assign last_i   = ({1'b0, i} + 3'd1) >= {1'b0, n};
  assign hi       = (ss == 2'd1) ? 2'd2 : 2'd1;
  assign lo       = hi - 2'd1;
  assign new_slot = (n == CNT_W'(MAX_COMP)) ? SLOT_W'(MAX_COMP - 1) : n;
  assign match    = !found && ({tmp[31:0], 8'h00} <= mul_p[39:0] ||
                    (mul_p[47:40] != 8'h00));
  assign mean_sum = {1'b0, tmp[32:0]} + {2'b00, mul_p[31:0]} + 34'd32768;
  assign var_sum  = {1'b0, mul_p[40:0], 8'h00} + {2'b00, tmp[47:0]} + 50'd8388608;
  assign dec_sum  = mul_p[32:0] + 33'd32768;
  assign wt_sum   = {1'b0, mul_p[32:0]} + {2'b00, learn_rate, 16'h0000} + 34'd32768;
  assign sum_all  = ((n > 2'd0) ? {2'b00, cw[0]} : 18'd0) +
                    ((n > 2'd1) ? {2'b00, cw[1]} : 18'd0) +
                    ((n > 2'd2) ? {2'b00, cw[2]} : 18'd0);
  assign mdiff    = (cl[0] > x) ? cl[0] - x : x - cl[0];

  // Select the multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_IDLE: begin
        mul_a = MUL_A_W'(match_sigma);
        mul_b = MUL_B_W'(match_sigma);
      end
      S_MD, S_UV1: begin
        mul_a = MUL_A_W'(ad);
        mul_b = MUL_B_W'(ad);
      end
      S_MV: begin
        mul_a = MUL_A_W'(cv[i]);
        mul_b = sig2;
      end
      S_DW, S_UW1: begin
        mul_a = MUL_A_W'(cw[i]);
        mul_b = MUL_B_W'(keep);
      end
      S_UM1: begin
        mul_a = MUL_A_W'(cm[i]);
        mul_b = MUL_B_W'(keep);
      end
      S_UM2: begin
        mul_a = MUL_A_W'(xs);
        mul_b = MUL_B_W'(learn_rate);
      end
      S_UV2: begin
        mul_a = mul_p[31:0];
        mul_b = MUL_B_W'(learn_rate);
      end
      S_UV3: begin
        mul_a = MUL_A_W'(cv[i]);
        mul_b = MUL_B_W'(keep);
      end
      S_R1: begin
        mul_a = MUL_A_W'(cw[hi]);
        mul_b = MUL_B_W'(cw[hi]);
      end
      S_R2: begin
        mul_a = mul_p[31:0];
        mul_b = cv[lo];
      end
      S_R3: begin
        mul_a = MUL_A_W'(cw[lo]);
        mul_b = MUL_B_W'(cw[lo]);
      end
      S_R4: begin
        mul_a = mul_p[31:0];
        mul_b = cv[hi];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gmm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign div_start = (state == S_DIV);

  gmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cw[i]),
    .divisor  (sum),
    .done     (div_done),
    .quot     (quot)
  );

  // Store requests: read on accept, write back once per item
  always_comb begin
    st_req.rd    = in_acc;
    st_req.wr    = (state == S_WRITE);
    st_req.addr  = in_acc ? in_data.pixel_index : idx;
    st_req.count = n;
  end

  always_comb begin
    for (int k = 0; k < MAX_COMP; k++) begin
      wr_row[k*ENTRY_W +: ENTRY_W] = {cw[k], cm[k], cv[k], cl[k]};
    end
  end

  gmm_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (st_req),
    .wr_row   (wr_row),
    .rd_count (rd_count),
    .rd_row   (rd_row),
    .clearing (clearing)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate       <= RST_LEARN_RATE;
      match_sigma      <= RST_MATCH_SIGMA;
      mask_threshold   <= RST_MASK_THRESHOLD;
      initial_weight   <= RST_INITIAL_WEIGHT;
      initial_variance <= RST_INITIAL_VARIANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEARN_RATE:       learn_rate       <= cfg_data[15:0];
        CFG_MATCH_SIGMA:      match_sigma      <= cfg_data[11:0];
        CFG_MASK_THRESHOLD:   mask_threshold   <= cfg_data[7:0];
        CFG_INITIAL_WEIGHT:   initial_weight   <= cfg_data[15:0];
        CFG_INITIAL_VARIANCE: initial_variance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= ({1'b0, in_data.pixel_index} >= 19'(PIXEL_COUNT)) ? S_DONE : S_RD;
          end
        end
        S_RD: begin
          if (rd_count == '0) begin
            state <= S_NEW;
          end else begin
            state <= S_MD;
          end
        end
        S_MD:  state <= S_MV;
        S_MV:  state <= S_MT;
        S_MT:  state <= match ? S_UM1 : S_DW;
        S_DW:  state <= S_DW2;
        S_UM1: state <= S_UM2;
        S_UM2: state <= S_UM3;
        S_UM3: state <= S_UV1;
        S_UV1: state <= S_UV2;
        S_UV2: state <= S_UV3;
        S_UV3: state <= S_UV4;
        S_UV4: state <= S_UW1;
        S_UW1: state <= S_UW2;
        S_DW2, S_UW2: begin
          if (!last_i) begin
            state <= S_MD;
          end else if (found || state == S_UW2) begin
            state <= S_SUM;
          end else if (n == CNT_W'(MAX_COMP)) begin
            state <= S_R1;
          end else begin
            state <= S_NEW;
          end
        end
        S_NEW: state <= S_SUM;
        S_SUM: begin
          if (sum_all != '0) begin
            state <= S_DIV;
          end else if (n > 2'd1) begin
            state <= S_R1;
          end else begin
            state <= S_WRITE;
          end
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            if (!last_i) begin
              state <= S_DIV;
            end else if (n > 2'd1) begin
              state <= S_R1;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_R1: state <= S_R2;
        S_R2: state <= S_R3;
        S_R3: state <= S_R4;
        S_R4: state <= S_R5;
        S_R5: begin
          if ((ss == 2'd0 && n == CNT_W'(MAX_COMP)) || ss == 2'd1) begin
            state <= S_R1;
          end else begin
            state <= pass ? S_WRITE : S_NEW;
          end
        end
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          x   <= in_data.pixel_value;
          idx <= in_data.pixel_index;
          oor <= ({1'b0, in_data.pixel_index} >= 19'(PIXEL_COUNT));
        end
      end
      S_RD: begin
        sig2  <= mul_p[23:0];
        n     <= rd_count;
        i     <= '0;
        found <= 1'b0;
        ss    <= '0;
        pass  <= 1'b0;
        for (int k = 0; k < MAX_COMP; k++) begin
          cw[k] <= rd_row[k*ENTRY_W+48 +: 16];
          cm[k] <= rd_row[k*ENTRY_W+32 +: 16];
          cv[k] <= rd_row[k*ENTRY_W+8  +: 24];
          cl[k] <= rd_row[k*ENTRY_W    +: 8];
        end
      end
      S_MV: tmp <= {24'h000000, mul_p[31:0]};
      S_MT: begin
        if (match) begin
          found <= 1'b1;
          cl[i] <= x;
        end
      end
      S_UM2: tmp <= mul_p;
      S_UM3: cm[i] <= (mean_sum[33:32] != 2'b00) ? 16'hFFFF : mean_sum[31:16];
      S_UV3: tmp <= mul_p;
      S_UV4: cv[i] <= (var_sum[49:48] != 2'b00) ? 24'hFFFFFF : var_sum[47:24];
      S_DW2, S_UW2: begin
        if (state == S_DW2) begin
          cw[i] <= dec_sum[32] ? 16'hFFFF : dec_sum[31:16];
        end else begin
          cw[i] <= (wt_sum[33:32] != 2'b00) ? 16'hFFFF : wt_sum[31:16];
        end
        if (!last_i) begin
          i <= i + 1'b1;
        end
        ss <= '0;
      end
      S_NEW: begin
        cw[new_slot] <= initial_weight;
        cm[new_slot] <= xs;
        cv[new_slot] <= initial_variance;
        cl[new_slot] <= x;
        if (n != CNT_W'(MAX_COMP)) begin
          n <= n + 1'b1;
        end
      end
      S_SUM: begin
        sum  <= sum_all;
        i    <= '0;
        ss   <= '0;
        pass <= 1'b1;
      end
      S_DIVW: begin
        if (div_done) begin
          cw[i] <= quot[16] ? 16'hFFFF : quot[15:0];
          if (!last_i) begin
            i <= i + 1'b1;
          end
        end
      end
      S_R3: tmp <= mul_p;
      S_R5: begin
        // Swap when the upper slot ranks strictly above the lower one
        if (tmp > mul_p) begin
          cw[hi] <= cw[lo];
          cw[lo] <= cw[hi];
          cm[hi] <= cm[lo];
          cm[lo] <= cm[hi];
          cv[hi] <= cv[lo];
          cv[lo] <= cv[hi];
          cl[hi] <= cl[lo];
          cl[lo] <= cl[hi];
        end
        ss <= ss + 2'd1;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.pixel_position <= idx;
          out_data.mask_value     <= (!oor && mdiff <= mask_threshold) ? MASK_BG : MASK_FG;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVW)
    else $error("divider finished outside its wait step");

  a_no_write_clearing: assert property (@(posedge clk) disable iff (rst)
    st_req.wr |-> !clearing && n != '0)
    else $error("writeback during clearing or with an empty mixture");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == S_RD || state == S_DONE)
    else $error("accepted item did not start its read");
`endif

endmodule
